/* rtl/fdl_pkg.sv */
`timescale 1ns / 1ps

package fdl_pkg;

  // Defaults for the top-level parameters
  localparam int STORE_DEPTH = 8192;
  localparam int FRAC_BITS   = 8;
  localparam int SAMPLE_BITS = 24;

  // Fixed field widths
  localparam int LEN_REG_W  = 14;
  localparam int DELAY_W    = 21;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 14;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_FROM_INPUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FROM_INPUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_DELAY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_GAIN       = 3'd4;

  // Register reset values
  localparam logic [LEN_REG_W-1:0] LINE_LENGTH_RST = 14'd4801;
  localparam logic [DELAY_W-1:0]   FIXED_DELAY_RST = 21'd1228800;
  localparam logic [GAIN_W-1:0]    FIXED_GAIN_RST  = 16'd1638;

  typedef struct packed {
    logic [LEN_REG_W-1:0] line_length;
    logic                 delay_from_input;
    logic                 gain_from_input;
    logic [DELAY_W-1:0]   fixed_delay;
    logic [GAIN_W-1:0]    fixed_gain;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic mod_init;
    logic mod_step;
    logic mod_fin;
    logic idx;
    logic rd1;
    logic rd2;
    logic mul1;
    logic interp;
    logic mul2;
    logic write;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic need_mod;
    logic mod_last;
  } sts_t;

endpackage

/* rtl/fdl_ctrl.sv */
`timescale 1ns / 1ps

module fdl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fdl_pkg::sts_t sts_i,
  output fdl_pkg::cmd_t cmd_o
);

  typedef enum logic [12:0] {
    ST_CLEAR  = 13'b0000000000001,
    ST_IDLE   = 13'b0000000000010,
    ST_PREP   = 13'b0000000000100,
    ST_MOD    = 13'b0000000001000,
    ST_MODFIN = 13'b0000000010000,
    ST_IDX    = 13'b0000000100000,
    ST_RD1    = 13'b0000001000000,
    ST_RD2    = 13'b0000010000000,
    ST_MUL1   = 13'b0000100000000,
    ST_INTERP = 13'b0001000000000,
    ST_MUL2   = 13'b0010000000000,
    ST_WRITE  = 13'b0100000000000,
    ST_FIN    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Clear the store after reset, then sequence one word at a time through the datapath
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.mod_init = 1'b1;
        state_d        = sts_i.need_mod ? ST_MOD : ST_IDX;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = ST_MODFIN;
      end
      ST_MODFIN: begin
        cmd_o.mod_fin = 1'b1;
        state_d       = ST_IDX;
      end
      ST_IDX: begin
        cmd_o.idx = 1'b1;
        state_d   = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rd1 = 1'b1;
        state_d   = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd2 = 1'b1;
        state_d   = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_INTERP;
      end
      ST_INTERP: begin
        cmd_o.interp = 1'b1;
        state_d      = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result word until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/fdl_dp.sv */
`timescale 1ns / 1ps

module fdl_dp #(
  parameter int STORE_DEPTH = fdl_pkg::STORE_DEPTH,
  parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS,
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fdl_pkg::cfg_t                     cfg_i,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_i,
  input  logic [fdl_pkg::DELAY_W-1:0]       delay_samples_i,
  input  logic signed [fdl_pkg::GAIN_W-1:0] gain_sample_i,
  input  fdl_pkg::cmd_t                     cmd_i,
  output fdl_pkg::sts_t                     sts_o,
  output logic signed [SAMPLE_BITS-1:0]     tap_sample_o
);

  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int LEN_W  = AW + 1;
  localparam int LREG_W = fdl_pkg::LEN_REG_W;
  localparam int CMP_W  = (LREG_W > LEN_W) ? LREG_W : LEN_W;
  localparam int SPAN_W = LEN_W + FRAC_BITS;
  localparam int DW     = fdl_pkg::DELAY_W;
  localparam int DC_W   = (DW > SPAN_W) ? DW : SPAN_W;
  localparam int ID_W   = DW - FRAC_BITS;
  localparam int IX_W   = ((ID_W > LEN_W) ? ID_W : LEN_W) + 1;
  localparam int R_W    = SPAN_W + 1;
  localparam int CNT_W  = $clog2(DW + 1);
  localparam int GW     = fdl_pkg::GAIN_W;
  localparam int GF     = fdl_pkg::GAIN_FRAC;
  localparam int P1_W   = FRAC_BITS + SAMPLE_BITS + 2;
  localparam int P2_W   = SAMPLE_BITS + GW;
  localparam int FB_W   = P2_W + 1 - GF;
  localparam int WR_W   = ((FB_W > SAMPLE_BITS) ? FB_W : SAMPLE_BITS) + 1;

  localparam logic signed [P1_W-1:0] P1_HALF = P1_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [P2_W:0]   P2_HALF = (P2_W + 1)'(1) <<< (GF - 1);
  localparam logic signed [WR_W-1:0] S_MAX   = (WR_W'(1) <<< (SAMPLE_BITS - 1)) - WR_W'(1);
  localparam logic signed [WR_W-1:0] S_MIN   = -(WR_W'(1) <<< (SAMPLE_BITS - 1));

  // Sample store
  logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic                   mem_we;
  logic [AW-1:0]          mem_wa, mem_ra;
  logic [SAMPLE_BITS-1:0] mem_wd;
  logic signed [SAMPLE_BITS-1:0] rd_q;

  // Control state
  logic [AW-1:0] clr_q, wi_q;

  // Per-word registers
  logic signed [SAMPLE_BITS-1:0] x_q, s1_q, y_q, out_q;
  logic signed [GW-1:0]          g_q;
  logic [DW-1:0]                 d_q, n_q;
  logic [LEN_W-1:0]              len_q;
  logic [SPAN_W-1:0]             span_q;
  logic [AW-1:0]                 w_q, i1_q, i2_q;
  logic                          need_mod_q;
  logic [R_W-1:0]                r_q;
  logic [CNT_W-1:0]              cnt_q;
  logic signed [P1_W-1:0]        prod1_q;
  logic signed [P2_W-1:0]        prod2_q;

  // Load-time selection
  logic [CMP_W-1:0]  lreg_ext;
  logic [LEN_W-1:0]  len_c, len_m1;
  logic [SPAN_W-1:0] span_c;
  logic [DW-1:0]     d_sel, d_load;
  logic [DC_W-1:0]   d_ext, span_ext;
  logic              clamp_mode, need_mod_c;
  logic [AW-1:0]     w_c;

  always_comb begin
    lreg_ext = CMP_W'(cfg_i.line_length);
    if (lreg_ext < CMP_W'(2)) begin
      len_c = LEN_W'(2);
    end else if (lreg_ext > CMP_W'(STORE_DEPTH)) begin
      len_c = LEN_W'(STORE_DEPTH);
    end else begin
      len_c = LEN_W'(lreg_ext);
    end
    len_m1     = len_c - LEN_W'(1);
    span_c     = {len_c, {FRAC_BITS{1'b0}}};
    d_sel      = cfg_i.delay_from_input ? delay_samples_i : cfg_i.fixed_delay;
    clamp_mode = cfg_i.delay_from_input && !cfg_i.gain_from_input;
    d_ext      = DC_W'(d_sel);
    span_ext   = DC_W'(span_c);
    if (clamp_mode && (d_ext >= span_ext)) begin
      d_load = DW'({len_m1, {FRAC_BITS{1'b0}}});
    end else begin
      d_load = d_sel;
    end
    need_mod_c = !clamp_mode && (d_ext > span_ext);
    w_c        = ({1'b0, wi_q} >= len_c) ? '0 : wi_q;
  end

  // Remainder step: shift in one dividend bit, subtract the span if it fits
  logic [R_W-1:0] r_sh;
  assign r_sh = {r_q[R_W-2:0], n_q[DW-1]};

  // Read indexes behind the write position
  logic [IX_W-1:0] idel_x, w_x, l_x, i1_x;
  logic [LEN_W-1:0] i2_x;

  always_comb begin
    idel_x = IX_W'(d_q[DW-1:FRAC_BITS]);
    w_x    = IX_W'(w_q);
    l_x    = IX_W'(len_q);
    if (w_x >= idel_x) begin
      i1_x = w_x - idel_x;
    end else begin
      i1_x = w_x + l_x - idel_x;
    end
    if (i1_x >= l_x) i1_x = '0;
    i2_x = {1'b0, i1_q} + LEN_W'(1);
    if (i2_x >= len_q) i2_x = '0;
  end

  // Interpolation and feedback arithmetic
  logic signed [P1_W-1:0]        frac_x, diff_x, p1_sum, p1_shr;
  logic signed [SAMPLE_BITS-1:0] y_d;
  logic signed [P2_W:0]          p2_sum, p2_shr;
  logic signed [FB_W-1:0]        fb;
  logic signed [WR_W-1:0]        wr_sum;
  logic signed [SAMPLE_BITS-1:0] wr_sat;
  logic [LEN_W-1:0]              w_inc;

  always_comb begin
    frac_x = P1_W'(signed'({1'b0, d_q[FRAC_BITS-1:0]}));
    diff_x = P1_W'(rd_q) - P1_W'(s1_q);
    p1_sum = prod1_q + P1_HALF;
    p1_shr = p1_sum >>> FRAC_BITS;
    y_d    = s1_q + SAMPLE_BITS'(p1_shr);
    p2_sum = (P2_W + 1)'(prod2_q) + P2_HALF;
    p2_shr = p2_sum >>> GF;
    fb     = FB_W'(p2_shr);
    wr_sum = WR_W'(x_q) + WR_W'(fb);
    if (wr_sum > S_MAX) begin
      wr_sat = SAMPLE_BITS'(S_MAX);
    end else if (wr_sum < S_MIN) begin
      wr_sat = SAMPLE_BITS'(S_MIN);
    end else begin
      wr_sat = SAMPLE_BITS'(wr_sum);
    end
    w_inc = {1'b0, w_q} + LEN_W'(1);
    if (w_inc >= len_q) w_inc = '0;
  end

  // Store port selection
  assign mem_we = cmd_i.clear || cmd_i.write;
  assign mem_wa = cmd_i.clear ? clr_q : w_q;
  assign mem_wd = cmd_i.clear ? '0 : wr_sat;
  assign mem_ra = cmd_i.rd2 ? i2_q : i1_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i) begin
    rd_q <= signed'(mem[mem_ra]);
  end

  // Clear sweep and write position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      wi_q  <= '0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + AW'(1);
      if (cmd_i.write) wi_q <= AW'(w_inc);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q        <= in_sample_i;
      d_q        <= d_load;
      g_q        <= cfg_i.gain_from_input ? gain_sample_i : signed'(cfg_i.fixed_gain);
      len_q      <= len_c;
      span_q     <= span_c;
      w_q        <= w_c;
      need_mod_q <= need_mod_c;
    end
    if (cmd_i.mod_init) begin
      n_q   <= d_q - DW'(1);
      r_q   <= '0;
      cnt_q <= CNT_W'(DW);
    end
    if (cmd_i.mod_step) begin
      r_q   <= (r_sh >= R_W'(span_q)) ? (r_sh - R_W'(span_q)) : r_sh;
      n_q   <= n_q << 1;
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.mod_fin) d_q <= DW'(r_q + R_W'(1));
    if (cmd_i.idx) i1_q <= AW'(i1_x);
    if (cmd_i.rd1) i2_q <= AW'(i2_x);
    if (cmd_i.rd2) s1_q <= rd_q;
    if (cmd_i.mul1) prod1_q <= frac_x * diff_x;
    if (cmd_i.interp) y_q <= y_d;
    if (cmd_i.mul2) prod2_q <= P2_W'(y_q) * P2_W'(g_q);
    if (cmd_i.out_load) out_q <= y_q;
  end

  assign sts_o.clr_last = (clr_q == AW'(STORE_DEPTH - 1));
  assign sts_o.need_mod = need_mod_q;
  assign sts_o.mod_last = (cnt_q == CNT_W'(1));
  assign tap_sample_o   = out_q;

endmodule

/* rtl/fractional_delay_feedback_line_top.sv */
`timescale 1ns / 1ps

// Fractional delay line with linear interpolation and feedback. Each input word
// reads two neighboring stored samples behind the write position, blends them by
// the fractional delay and returns the result; the input plus the result times the
// feedback gain, saturated, is written back. Only one word is in flight at a time; when
// the delay is wrapped and exceeds the line length, a 21-step remainder unit first
// reduces it. The store has one write and one read port, so the two reads and the write
// go one after another. After reset the store is swept to zero, one entry per cycle,
// over all STORE_DEPTH entries (8192 by default) before the first word is taken;
// configuration writes are taken at any time but must only be issued while no word is
// in flight.
module fractional_delay_feedback_line_top #(
  parameter int STORE_DEPTH = fdl_pkg::STORE_DEPTH,
  parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS,
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fdl_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [fdl_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_i,
  input  logic [fdl_pkg::DELAY_W-1:0]          delay_samples_i,
  input  logic signed [fdl_pkg::GAIN_W-1:0]    gain_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        tap_sample_o
);

  fdl_pkg::cfg_t cfg_q;
  fdl_pkg::cmd_t cmd;
  fdl_pkg::sts_t sts;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_length      <= fdl_pkg::LINE_LENGTH_RST;
      cfg_q.delay_from_input <= 1'b0;
      cfg_q.gain_from_input  <= 1'b0;
      cfg_q.fixed_delay      <= fdl_pkg::FIXED_DELAY_RST;
      cfg_q.fixed_gain       <= fdl_pkg::FIXED_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fdl_pkg::REG_LINE_LENGTH:
          cfg_q.line_length <= cfg_data_i[fdl_pkg::LEN_REG_W-1:0];
        fdl_pkg::REG_DELAY_FROM_INPUT: cfg_q.delay_from_input <= cfg_data_i[0];
        fdl_pkg::REG_GAIN_FROM_INPUT:  cfg_q.gain_from_input  <= cfg_data_i[0];
        fdl_pkg::REG_FIXED_DELAY:
          cfg_q.fixed_delay <= cfg_data_i[fdl_pkg::DELAY_W-1:0];
        fdl_pkg::REG_FIXED_GAIN:
          cfg_q.fixed_gain <= cfg_data_i[fdl_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  fdl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fdl_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_sample_i     (in_sample_i),
    .delay_samples_i (delay_samples_i),
    .gain_sample_i   (gain_sample_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .tap_sample_o    (tap_sample_o)
  );

endmodule

/* rtl/fdl_checker.sv */
`timescale 1ns / 1ps

module fdl_checker #(
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] tap_sample_o
);

  // One word at a time: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a word is in flight");

  // A fresh result appears only as the block returns to idle
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $rose(in_ready_o))
    else $error("result word raised outside the return to idle");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tap_sample_o))
    else $error("stalled result word changed or dropped");

  // A result leaves only when taken
  a_out_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result word dropped without being taken");

endmodule

bind fractional_delay_feedback_line_top fdl_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_fdl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .tap_sample_o (tap_sample_o)
);

/* tb/fractional_delay_feedback_line_top_tb.sv */
`timescale 1ns / 1ps

module fractional_delay_feedback_line_top_tb;

  localparam int SW = fdl_pkg::SAMPLE_BITS;
  localparam int DW = fdl_pkg::DELAY_W;
  localparam int GW = fdl_pkg::GAIN_W;
  localparam int LW = fdl_pkg::LEN_REG_W;
  localparam int FB = fdl_pkg::FRAC_BITS;
  localparam int GF = fdl_pkg::GAIN_FRAC;
  localparam int DEPTH = fdl_pkg::STORE_DEPTH;
  localparam int IW = fdl_pkg::CFG_IDX_W;
  localparam int CW = fdl_pkg::CFG_DATA_W;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [GW-1:0] GAIN_MAX = 16'sh7FFF;
  localparam logic signed [GW-1:0] GAIN_MIN = 16'sh8000;
  localparam logic [DW-1:0] DELAY_MAX = {DW{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IW-1:0] cfg_idx_i = '0;
  logic [CW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SW-1:0] in_sample_i = '0;
  logic [DW-1:0] delay_samples_i = '0;
  logic signed [GW-1:0] gain_sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SW-1:0] tap_sample_o;

  fractional_delay_feedback_line_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_sample_i(in_sample_i),
    .delay_samples_i(delay_samples_i),
    .gain_sample_i(gain_sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .tap_sample_o(tap_sample_o)
  );

  // Mirror of the line: register copies, sample store and write position
  logic [LW-1:0] cfg_len;
  logic cfg_dly_sel;
  logic cfg_gain_sel;
  logic [DW-1:0] cfg_fix_dly;
  logic signed [GW-1:0] cfg_fix_gain;
  logic signed [SW-1:0] tap_mem [DEPTH];
  int wr_pos;

  logic signed [SW-1:0] exp_out_q[$];
  int err_cnt = 0;
  int idle_cycles = 0;

  // Sender and receiver pacing
  bit gaps_on = 1'b1;
  int burst_left = 0;
  int hold_req_cnt = 0;
  int hold_seen_cnt = 0;
  int hold_left = 0;
  logic [9:0] rx_phase = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_len(input longint raw_len);
    if (raw_len < 2) return 2;
    if (raw_len > DEPTH) return DEPTH;
    return raw_len;
  endfunction

  // Compute the interpolated tap for one word and write back the feedback sum
  function automatic logic signed [SW-1:0] interp_feedback_step(
    input logic signed [SW-1:0] smp,
    input logic [DW-1:0] dly_in,
    input logic signed [GW-1:0] gain_in
  );
    longint len, span, w, d, idel, frac, i1, i2;
    longint x, g, s1, s2, y, fb, wr;
    longint smax, smin;
    smax = (longint'(1) << (SW - 1)) - 1;
    smin = -smax - 1;
    len = clamp_len(longint'(cfg_len));
    span = len << FB;
    w = wr_pos;
    if (w >= len) w = 0;
    x = smp;
    if (cfg_dly_sel) d = longint'(dly_in);
    else d = longint'(cfg_fix_dly);
    if (cfg_gain_sel) g = gain_in;
    else g = cfg_fix_gain;
    // Clamp in per-word delay mode with register gain, wrap otherwise
    if (cfg_dly_sel && !cfg_gain_sel) begin
      if (d >= span) d = (len - 1) << FB;
    end else if (d > span) begin
      d = (d - 1) % span + 1;
    end
    idel = d >> FB;
    frac = d & ((longint'(1) << FB) - 1);
    i1 = (w >= idel) ? (w - idel) : (w + len - idel);
    if (i1 >= len) i1 = 0;
    i2 = i1 + 1;
    if (i2 >= len) i2 = 0;
    s1 = tap_mem[i1];
    s2 = tap_mem[i2];
    y = s1 + ((frac * (s2 - s1) + (longint'(1) << (FB - 1))) >>> FB);
    fb = (y * g + (longint'(1) << (GF - 1))) >>> GF;
    wr = x + fb;
    if (wr > smax) wr = smax;
    if (wr < smin) wr = smin;
    tap_mem[w] = wr[SW-1:0];
    w++;
    if (w >= len) w = 0;
    wr_pos = int'(w);
    return y[SW-1:0];
  endfunction

  // Track register writes, predict each accepted word, check each result
  always @(posedge clk_i) begin
    logic signed [SW-1:0] want;
    if (!rst_ni) begin
      cfg_len = fdl_pkg::LINE_LENGTH_RST;
      cfg_dly_sel = 1'b0;
      cfg_gain_sel = 1'b0;
      cfg_fix_dly = fdl_pkg::FIXED_DELAY_RST;
      cfg_fix_gain = fdl_pkg::FIXED_GAIN_RST;
      foreach (tap_mem[k]) tap_mem[k] = '0;
      wr_pos = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fdl_pkg::REG_LINE_LENGTH:      cfg_len = cfg_data_i[LW-1:0];
          fdl_pkg::REG_DELAY_FROM_INPUT: cfg_dly_sel = cfg_data_i[0];
          fdl_pkg::REG_GAIN_FROM_INPUT:  cfg_gain_sel = cfg_data_i[0];
          fdl_pkg::REG_FIXED_DELAY:      cfg_fix_dly = cfg_data_i[DW-1:0];
          fdl_pkg::REG_FIXED_GAIN:       cfg_fix_gain = cfg_data_i[GW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o)
        exp_out_q.push_back(interp_feedback_step(in_sample_i, delay_samples_i,
                                                 gain_sample_i));
      if (out_valid_o && out_ready_i) begin
        if (exp_out_q.size() == 0) begin
          $error("tap_sample: unexpected word %0d", tap_sample_o);
          err_cnt++;
        end else begin
          want = exp_out_q.pop_front();
          if (tap_sample_o !== want) begin
            $error("tap_sample: expected %0d, got %0d", want, tap_sample_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // Drop the run when no word moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: long hold on request, otherwise a rotating stall pattern
  always @(negedge clk_i) begin
    if (hold_seen_cnt != hold_req_cnt) begin
      hold_seen_cnt <= hold_req_cnt;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      rx_phase <= rx_phase + 1'b1;
      case (rx_phase[9:8])
        2'd0: out_ready_i <= 1'b1;
        2'd1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= (rx_phase[4:0] < 5'd7);
      endcase
    end
  end

  // Offer one word, with a random gap at the end of each burst
  task automatic send_word(input logic signed [SW-1:0] smp, input logic [DW-1:0] dly,
                           input logic signed [GW-1:0] gn);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 40);
      burst_left = $urandom_range(1, 24);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_sample_i <= smp;
    delay_samples_i <= dly;
    gain_sample_i <= gn;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every word is back and the line is idle
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (exp_out_q.size() != 0 || !in_ready_o);
  endtask

  task automatic set_config(input int len, input bit dsel, input bit gsel,
                            input logic [DW-1:0] fdly, input logic signed [GW-1:0] fgain);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= fdl_pkg::REG_LINE_LENGTH;
    cfg_data_i <= CW'(len[LW-1:0]);
    @(negedge clk_i);
    cfg_idx_i <= fdl_pkg::REG_DELAY_FROM_INPUT;
    cfg_data_i <= CW'(dsel);
    @(negedge clk_i);
    cfg_idx_i <= fdl_pkg::REG_GAIN_FROM_INPUT;
    cfg_data_i <= CW'(gsel);
    @(negedge clk_i);
    cfg_idx_i <= fdl_pkg::REG_FIXED_DELAY;
    cfg_data_i <= CW'(fdly);
    @(negedge clk_i);
    cfg_idx_i <= fdl_pkg::REG_FIXED_GAIN;
    cfg_data_i <= CW'($unsigned(fgain));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      3: return SW'($signed($urandom_range(0, 2000)) - 1000);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic signed [GW-1:0] rand_gain();
    case ($urandom_range(0, 9))
      0: return GAIN_MAX;
      1: return GAIN_MIN;
      2: return '0;
      3: return 16'sd16384;
      4, 5, 6: return GW'($signed($urandom_range(0, 8192)) - 4096);
      default: return GW'($urandom);
    endcase
  endfunction

  // Delay mostly inside the line, sometimes at its edge, beyond it or anywhere
  function automatic logic [DW-1:0] rand_delay(input int raw_len);
    longint len, span, hi;
    len = clamp_len(raw_len);
    span = len << FB;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return DW'($urandom_range(0, int'(span - 1)));
      5: return DW'(span + $urandom_range(0, 2) - 1);
      6: begin
        hi = (span * 4 > DELAY_MAX) ? DELAY_MAX : span * 4;
        return DW'($urandom_range(0, int'(hi)));
      end
      7: return DW'($urandom);
      8: return DELAY_MAX;
      default: begin
        case ($urandom_range(0, 2))
          0: return DW'((longint'($urandom_range(0, int'(len - 1))) << FB));
          1: return DW'((longint'($urandom_range(0, int'(len - 1))) << FB) | 128);
          default: return DW'((longint'($urandom_range(0, int'(len - 1))) << FB) | 255);
        endcase
      end
    endcase
  endfunction

  function automatic int rand_len();
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 1));
      1: return 2;
      2, 3, 4: return int'($urandom_range(3, 40));
      5: return int'($urandom_range(41, 600));
      6: return int'($urandom_range(601, 8191));
      7: return DEPTH;
      8: return int'($urandom_range(DEPTH + 1, 16383));
      default: return int'($urandom_range(2, 16));
    endcase
  endfunction

  // Reset settings: fixed delay just short of the line, store still empty
  task automatic test_reset_defaults();
    settle();
    send_word(SMP_MAX, '0, '0);
    send_word(SMP_MIN, DELAY_MAX, GAIN_MAX);
    send_word('0, '0, GAIN_MIN);
  endtask

  // Per-word delay with register gain: delays at or past the line clamp
  task automatic test_delay_clamp();
    settle();
    set_config(16, 1'b1, 1'b0, '0, GAIN_MAX);
    send_word(SMP_MAX, 21'd0, '0);
    send_word(SMP_MIN, 21'd256, '0);
    send_word(24'sd123456, 21'd4095, '0);
    send_word(-24'sd1, 21'd4096, '0);
    send_word(SMP_MAX, DELAY_MAX, '0);
    send_word(24'sd1001, 21'd640, '0);
  endtask

  // Per-word gain: delays past the line wrap, feedback saturates both ways
  task automatic test_delay_wrap();
    settle();
    set_config(16, 1'b1, 1'b1, '0, GAIN_MIN);
    send_word(SMP_MAX, 21'd4096, GAIN_MAX);
    send_word(SMP_MAX, 21'd4097, GAIN_MAX);
    send_word(SMP_MIN, DELAY_MAX, GAIN_MIN);
    send_word(SMP_MIN, 21'd0, GAIN_MAX);
    send_word(24'sd777, 21'd1535, 16'sd16384);
    send_word(-24'sd5, 21'd383, '0);
  endtask

  // Lengths beyond the store, below two, and a write position past the line
  task automatic test_length_limits();
    settle();
    set_config(16383, 1'b0, 1'b0, DELAY_MAX, 16'sd16384);
    send_word(SMP_MAX, '0, '0);
    send_word(24'sd4242, '0, '0);
    send_word(SMP_MIN, '0, '0);
    settle();
    set_config(0, 1'b0, 1'b0, 21'd384, 16'sd16384);
    send_word(24'sd1000, '0, '0);
    send_word(-24'sd3000, '0, '0);
    settle();
    set_config(1, 1'b0, 1'b1, 21'd513, GAIN_MIN);
    send_word(24'sd55555, '0, GAIN_MAX);
  endtask

  // Random settings per phase; one phase stalls the receiver for a long stretch
  task automatic test_random_traffic(input int phases, input int per_phase,
                                     input int pressure_phase);
    int len;
    bit dsel;
    bit gsel;
    for (int p = 0; p < phases; p++) begin
      settle();
      len = rand_len();
      dsel = 1'($urandom_range(0, 1));
      gsel = 1'($urandom_range(0, 1));
      set_config(len, dsel, gsel, rand_delay(len), rand_gain());
      gaps_on = (p != pressure_phase) && ($urandom_range(0, 4) != 0);
      burst_left = 0;
      for (int n = 0; n < per_phase; n++) begin
        if (p == pressure_phase && n == 10) hold_req_cnt++;
        send_word(rand_sample(), rand_delay(len), rand_gain());
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_delay_clamp();
    test_delay_wrap();
    test_length_limits();
    test_random_traffic(9, 100, 3);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
